FILE: src/srct_pkg.sv
// Package with constants and types for the sprite rectangle clipper.
package srct_pkg;
	localparam int NUM_REGS = 6;
	localparam int IDX_W = 3;
	typedef enum logic [IDX_W-1:0] {
		REG_WIN_LEFT   = 3'd0,
		REG_WIN_TOP    = 3'd1,
		REG_WIN_RIGHT  = 3'd2,
		REG_WIN_BOTTOM = 3'd3,
		REG_ORIGIN_X   = 3'd4,
		REG_ORIGIN_Y   = 3'd5
	} reg_idx_t;
endpackage

FILE: src/srct_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
interface srct_in_if #(parameter int CW = 16, parameter int TW = 17);
	logic valid;
	logic ready;
	logic signed [CW-1:0] rect_x, rect_y, rect_w, rect_h;
	logic [TW-1:0] tex_u_start, tex_v_start, tex_u_end, tex_v_end;
	modport source(output valid, rect_x, rect_y, rect_w, rect_h,
		tex_u_start, tex_v_start, tex_u_end, tex_v_end, input ready);
	modport sink(input valid, rect_x, rect_y, rect_w, rect_h,
		tex_u_start, tex_v_start, tex_u_end, tex_v_end, output ready);
endinterface

interface srct_out_if #(parameter int CW = 16, parameter int TW = 17);
	logic valid;
	logic ready;
	logic visible;
	logic signed [CW-1:0] clip_left, clip_top, clip_right, clip_bottom;
	logic [TW-1:0] out_u_start, out_v_start, out_u_end, out_v_end;
	modport source(output valid, visible, clip_left, clip_top, clip_right, clip_bottom,
		out_u_start, out_v_start, out_u_end, out_v_end, input ready);
	modport sink(input valid, visible, clip_left, clip_top, clip_right, clip_bottom,
		out_u_start, out_v_start, out_u_end, out_v_end, output ready);
endinterface

interface srct_cfg_if #(parameter int CW = 16);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [CW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/srct_front.sv
// Front stage: origin offset, corner sort, clamp and visibility test.
module srct_front import srct_pkg::*; #(
	parameter int CW = 16,
	parameter int TW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [CW-1:0] rect_x, rect_y, rect_w, rect_h,
	input  logic [TW-1:0]        tex_u_start, tex_v_start, tex_u_end, tex_v_end,
	input  logic signed [CW-1:0] win_l, win_t, win_r, win_b, org_x, org_y,
	output logic                 f_valid,
	input  logic                 f_ready,
	// Visibility flag, clip edges, low and high edge distances and span per axis, then start and end tex.
	output logic [(CW+2)*10+TW*4:0] f_data
);
	localparam int EW = CW + 2;
	logic signed [EW-1:0] sx1, sx2, sy1, sy2, cx1, cx2, cy1, cy2;
	logic vis;

	function automatic logic signed [EW-1:0] clampf(logic signed [EW-1:0] v,
		logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
		logic signed [EW-1:0] t;
		t = (v < EW'(lo)) ? EW'(lo) : v;
		return (t > EW'(hi)) ? EW'(hi) : t;
	endfunction

	always_comb begin
		logic signed [EW-1:0] x, y, w, h;
		x = EW'(rect_x); y = EW'(rect_y); w = EW'(rect_w); h = EW'(rect_h);
		sx1 = EW'(org_x) + ((w < 0) ? x + w : x);
		sx2 = EW'(org_x) + ((w < 0) ? x : x + w);
		sy1 = EW'(org_y) + ((h < 0) ? y + h : y);
		sy2 = EW'(org_y) + ((h < 0) ? y : y + h);
		cx1 = clampf(sx1, win_l, win_r);
		cx2 = clampf(sx2, win_l, win_r);
		cy1 = clampf(sy1, win_t, win_b);
		cy2 = clampf(sy2, win_t, win_b);
		vis = (cx2 > cx1) && (cy2 > cy1);
	end

	assign in_ready = !f_valid || f_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid <= 1'b0;
		end else if (in_ready) begin
			f_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_data <= {vis, cx1, cy1, cx2, cy2, cx1 - sx1, cy1 - sy1, cx2 - sx2, cy2 - sy2,
				sx2 - sx1, sy2 - sy1, tex_u_start, tex_v_start, tex_u_end, tex_v_end};
		end
	end
endmodule

FILE: src/srct_fifo.sv
// Small two-entry queue between the front and back stages.
module srct_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);
	logic [DW-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: src/srct_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor(num/den).
module srct_div #(
	parameter int NW = 40,
	parameter int DW = 18,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [DW:0]   rem_s [NW+1];
	logic [NW-1:0] n_s   [NW+1];
	logic [DW-1:0] d_s   [NW+1];
	logic [SW-1:0] sd_s  [NW+1];

	always_comb begin
		rem_s[0] = '0; n_s[0] = num; d_s[0] = den; sd_s[0] = side_in;
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW+1:0] t;
		assign t = {rem_s[i], n_s[i][NW-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= {2'b00, d_s[i]}) begin
					rem_s[i+1] <= (DW+1)'(t - {2'b00, d_s[i]});
					n_s[i+1] <= {n_s[i][NW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= t[DW:0];
					n_s[i+1] <= {n_s[i][NW-2:0], 1'b0};
				end
				d_s[i+1] <= d_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end
	assign quo = n_s[NW];
	assign side_out = sd_s[NW];
endmodule

FILE: src/srct_back.sv
// Back stage: texture products, four dividers, sign apply and saturation.
module srct_back #(
	parameter int CW = 16,
	parameter int TW = 17
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    b_valid,
	output logic                    b_ready,
	input  logic [(CW+2)*10+TW*4:0] b_data,
	output logic                    o_valid,
	input  logic                    o_ready,
	output logic                    o_visible,
	output logic signed [CW-1:0]    o_l, o_t, o_r, o_b,
	output logic [TW-1:0]           o_us, o_vs, o_ue, o_ve
);
	localparam int EW = CW + 2;
	localparam int PW = EW + TW + 1;
	localparam int DEPTH = PW + 2;
	localparam int SW = 1 + 4 * CW + TW + 1 + 1;
	localparam logic [TW:0] TMAX = {1'b0, {TW{1'b1}}};

	logic en;
	logic [DEPTH-1:0] v_q;
	assign en = !o_valid || o_ready;
	assign b_ready = en;

	logic vis;
	logic signed [EW-1:0] cx1, cy1, cx2, cy2, dx1, dy1, dx2, dy2, spx, spy;
	logic [TW-1:0] us, vs, ue, ve;
	assign {vis, cx1, cy1, cx2, cy2, dx1, dy1, dx2, dy2, spx, spy, us, vs, ue, ve} = b_data;

	// Stage 1: magnitudes and products.
	logic [PW-1:0] p_s1 [4];
	logic [EW-1:0] sp_s1 [4];
	logic [TW-1:0] st_s1 [4];
	logic neg_s1 [4];
	logic vis_s1;
	logic signed [CW-1:0] e_s1 [4];

	always_ff @(posedge clk) begin
		logic signed [TW:0] ex, ey;
		logic signed [TW:0] ext [4];
		logic signed [EW-1:0] dd [4];
		logic [TW-1:0] ae;
		logic [EW-1:0] ad;
		if (en) begin
			ex = $signed({1'b0, ue}) - $signed({1'b0, us});
			ey = $signed({1'b0, ve}) - $signed({1'b0, vs});
			ext[0] = ex; ext[1] = ey; ext[2] = ex; ext[3] = ey;
			dd[0] = dx1; dd[1] = dy1; dd[2] = dx2; dd[3] = dy2;
			for (int k = 0; k < 4; k++) begin
				ae = ext[k][TW] ? TW'(-ext[k]) : ext[k][TW-1:0];
				ad = dd[k][EW-1] ? EW'(-dd[k]) : dd[k];
				p_s1[k] <= PW'(ae * ad);
				neg_s1[k] <= (ext[k] < 0) != (dd[k] < 0);
			end
			sp_s1[0] <= spx; sp_s1[2] <= spx; sp_s1[1] <= spy; sp_s1[3] <= spy;
			st_s1[0] <= us; st_s1[1] <= vs; st_s1[2] <= ue; st_s1[3] <= ve;
			vis_s1 <= vis;
			e_s1[0] <= cx1[CW-1:0]; e_s1[1] <= cy1[CW-1:0];
			e_s1[2] <= cx2[CW-1:0]; e_s1[3] <= cy2[CW-1:0];
		end
	end

	logic [PW-1:0] q [4];
	logic [SW-1:0] so [4];
	for (genvar k = 0; k < 4; k++) begin : g_div
		logic [SW-1:0] si;
		assign si = {vis_s1, e_s1[0], e_s1[1], e_s1[2], e_s1[3], st_s1[k], neg_s1[k],
			1'b0};
		// A visible item always has a positive span; guard zero anyway.
		srct_div #(.NW(PW), .DW(EW), .SW(SW)) u_div (
			.clk(clk), .en(en), .num(p_s1[k]),
			.den((sp_s1[k] == '0) ? EW'(1) : sp_s1[k]),
			.side_in(si), .quo(q[k]), .side_out(so[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[DEPTH-2:0], b_valid};
		end
	end

	// Final stage: sign, saturate, zero when not visible.
	logic [TW-1:0] res [4];
	always_comb begin
		logic [TW-1:0] st;
		logic ng;
		logic signed [PW+1:0] r;
		for (int k = 0; k < 4; k++) begin
			st = so[k][TW+1:2];
			ng = so[k][1];
			r = ng ? $signed({2'b00, PW'(st)}) - $signed({2'b00, q[k]})
				: $signed({2'b00, PW'(st)}) + $signed({2'b00, q[k]});
			if (r < 0) res[k] = '0;
			else if (r > $signed((PW+2)'(TMAX))) res[k] = TMAX[TW-1:0];
			else res[k] = r[TW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		logic vv;
		if (en) begin
			vv = so[0][SW-1];
			o_visible <= vv;
			o_l <= vv ? so[0][SW-2 -: CW] : '0;
			o_t <= vv ? so[0][SW-2-CW -: CW] : '0;
			o_r <= vv ? so[0][SW-2-2*CW -: CW] : '0;
			o_b <= vv ? so[0][SW-2-3*CW -: CW] : '0;
			o_us <= vv ? res[0] : '0;
			o_vs <= vv ? res[1] : '0;
			o_ue <= vv ? res[2] : '0;
			o_ve <= vv ? res[3] : '0;
		end
	end
	assign o_valid = v_q[DEPTH-1];
endmodule

FILE: src/sprite_rect_clip_texcoord_top.sv
// Top level of the sprite rectangle clipper with texture coordinate adjust.
// Path from input transfer to result valid: the front register loads at the transfer, then the
// two-entry queue, a product stage, COORD_WIDTH+TEX_WIDTH+3 divider stages and an output register.
// Throughput: one item per cycle; the back pipeline stalls as a whole when the result is not
// taken, and the two-entry queue absorbs the front's items.
// Reset: arst_n clears all valid flags and loads the register reset values.
module sprite_rect_clip_texcoord_top import srct_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int TEX_WIDTH = 17
) (
	input logic clk,
	input logic arst_n,
	srct_in_if.sink   in_ch,
	srct_out_if.source out_ch,
	srct_cfg_if.sink  cfg
);
	localparam int FW = (COORD_WIDTH + 2) * 10 + TEX_WIDTH * 4 + 1;

	logic signed [COORD_WIDTH-1:0] regs_q [NUM_REGS];

	// Configuration writes complete every cycle; indexes past the list are dropped.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_WIN_LEFT] <= '0;
			regs_q[REG_WIN_TOP] <= '0;
			regs_q[REG_WIN_RIGHT] <= COORD_WIDTH'(32767);
			regs_q[REG_WIN_BOTTOM] <= COORD_WIDTH'(32767);
			regs_q[REG_ORIGIN_X] <= '0;
			regs_q[REG_ORIGIN_Y] <= '0;
		end else if (cfg.valid && cfg.index < 3'(NUM_REGS)) begin
			regs_q[cfg.index] <= cfg.data;
		end
	end

	logic f_valid, f_ready, b_valid, b_ready;
	logic [FW-1:0] f_data, b_data;

	srct_front #(.CW(COORD_WIDTH), .TW(TEX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.rect_x(in_ch.rect_x), .rect_y(in_ch.rect_y), .rect_w(in_ch.rect_w),
		.rect_h(in_ch.rect_h), .tex_u_start(in_ch.tex_u_start),
		.tex_v_start(in_ch.tex_v_start), .tex_u_end(in_ch.tex_u_end),
		.tex_v_end(in_ch.tex_v_end),
		.win_l(regs_q[REG_WIN_LEFT]), .win_t(regs_q[REG_WIN_TOP]),
		.win_r(regs_q[REG_WIN_RIGHT]), .win_b(regs_q[REG_WIN_BOTTOM]),
		.org_x(regs_q[REG_ORIGIN_X]), .org_y(regs_q[REG_ORIGIN_Y]),
		.f_valid(f_valid), .f_ready(f_ready), .f_data(f_data));

	srct_fifo #(.DW(FW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_data), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data));

	srct_back #(.CW(COORD_WIDTH), .TW(TEX_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .b_valid(b_valid), .b_ready(b_ready),
		.b_data(b_data), .o_valid(out_ch.valid), .o_ready(out_ch.ready),
		.o_visible(out_ch.visible), .o_l(out_ch.clip_left), .o_t(out_ch.clip_top),
		.o_r(out_ch.clip_right), .o_b(out_ch.clip_bottom), .o_us(out_ch.out_u_start),
		.o_vs(out_ch.out_v_start), .o_ue(out_ch.out_u_end), .o_ve(out_ch.out_v_end));
endmodule

FILE: src/srct_checker.sv
// Port-level checker for the clipper and its bind to the top level.
module srct_checker #(
	parameter int CW = 16,
	parameter int TW = 17
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic visible,
	input logic [CW-1:0] clip_left,
	input logic [TW-1:0] out_u_start,
	input logic cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> clip_left == 0 && out_u_start == 0)
		else $error("hidden result not zero");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config not ready");
endmodule

bind sprite_rect_clip_texcoord_top srct_checker #(.CW(COORD_WIDTH), .TW(TEX_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.visible(out_ch.visible), .clip_left(out_ch.clip_left),
	.out_u_start(out_ch.out_u_start), .cfg_ready(cfg.ready));

FILE: dv/sprite_rect_clip_texcoord_top_test.sv
// Self-checking testbench for the sprite rectangle clipper with texture coordinate adjust.
module sprite_rect_clip_texcoord_top_test;
	import srct_pkg::*;

	localparam int CW = 16;
	localparam int TW = 17;
	// This many idle cycles are enough to drain an item through the block.
	localparam int DRAIN_CYCLES = CW + TW + 40;
	localparam int CYCLE_LIMIT = 1500000;

	// These are the phases of handshake pressure applied to the two channels.
	typedef enum int {PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

	// One input rectangle with its texture rectangle.
	typedef struct packed {
		logic signed [CW-1:0] x, y, w, h;
		logic [TW-1:0] us, vs, ue, ve;
	} sprite_t;

	// One clipped result.
	typedef struct packed {
		logic vis;
		logic signed [CW-1:0] l, t, r, b;
		logic [TW-1:0] us, vs, ue, ve;
	} clip_t;

	logic clk;
	logic arst_n;
	srct_in_if  #(.CW(CW), .TW(TW)) in_ch();
	srct_out_if #(.CW(CW), .TW(TW)) out_ch();
	srct_cfg_if #(.CW(CW)) cfg();

	sprite_rect_clip_texcoord_top #(.COORD_WIDTH(CW), .TEX_WIDTH(TW)) uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg(cfg.sink)
	);

	// The testbench keeps its own copy of the window and origin registers.
	logic signed [CW-1:0] win_l, win_t, win_r, win_b, org_x, org_y;

	sprite_t pending_sprites[$];
	clip_t   expected_clips[$];
	phase_t  phase;
	int      cycle_count;
	int      hold_off;
	int      error_count;

	// The texture edge moves by extent*d/span, truncated toward zero, then it
	// is saturated to the texture field.
	function automatic logic [TW-1:0] shift_tex(longint start, longint extent, longint d,
			longint span);
		longint mag;
		longint r;
		if (span <= 0)
			return start[TW-1:0];
		mag = ((extent < 0 ? -extent : extent) * (d < 0 ? -d : d)) / span;
		r = ((extent < 0) != (d < 0)) ? start - mag : start + mag;
		if (r < 0)
			r = 0;
		if (r > (1 << TW) - 1)
			r = (1 << TW) - 1;
		return r[TW-1:0];
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	// Compute the clipped rectangle and adjusted texture coordinates.
	function automatic clip_t clip_sprite(sprite_t s);
		clip_t c;
		longint sx1, sx2, sy1, sy2, cx1, cx2, cy1, cy2;
		longint x, y, w, h, us, vs, ue, ve;
		x = s.x;
		y = s.y;
		w = s.w;
		h = s.h;
		us = s.us;
		vs = s.vs;
		ue = s.ue;
		ve = s.ve;
		// A negative size flips the rectangle, so the corners are sorted first.
		sx1 = longint'(org_x) + ((w < 0) ? x + w : x);
		sx2 = longint'(org_x) + ((w < 0) ? x : x + w);
		sy1 = longint'(org_y) + ((h < 0) ? y + h : y);
		sy2 = longint'(org_y) + ((h < 0) ? y : y + h);
		cx1 = clamp(sx1, win_l, win_r);
		cx2 = clamp(sx2, win_l, win_r);
		cy1 = clamp(sy1, win_t, win_b);
		cy2 = clamp(sy2, win_t, win_b);
		c = '0;
		if (cx2 - cx1 <= 0 || cy2 - cy1 <= 0)
			return c;
		c.vis = 1'b1;
		c.l = cx1[CW-1:0];
		c.t = cy1[CW-1:0];
		c.r = cx2[CW-1:0];
		c.b = cy2[CW-1:0];
		c.us = shift_tex(us, ue - us, cx1 - sx1, sx2 - sx1);
		c.vs = shift_tex(vs, ve - vs, cy1 - sy1, sy2 - sy1);
		c.ue = shift_tex(ue, ue - us, cx2 - sx2, sx2 - sx1);
		c.ve = shift_tex(ve, ve - vs, cy2 - sy2, sy2 - sy1);
		return c;
	endfunction

	// The clock has a period of two time units.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The driver offers the oldest pending sprite and drops it after its transfer.
	// Valid stays high across back-to-back transfers with a single assignment per edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			logic take;
			take = in_ch.valid && in_ch.ready;
			if (take) begin
				expected_clips.push_back(clip_sprite(pending_sprites.pop_front()));
			end
			if ((!in_ch.valid || take) && pending_sprites.size() > 0 &&
					!((phase == PH_SRC_IDLE && $urandom_range(99) < 74) ||
					(phase == PH_BOTH && $urandom_range(99) < 17))) begin
				in_ch.valid <= 1'b1;
				{in_ch.rect_x, in_ch.rect_y, in_ch.rect_w, in_ch.rect_h, in_ch.tex_u_start,
					in_ch.tex_v_start, in_ch.tex_u_end, in_ch.tex_v_end} <= pending_sprites[0];
			end else if (take) begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// The monitor drives ready and checks each result transfer against the oldest
	// expectation. A long hold-off keeps ready low so that the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				clip_t got;
				got = {out_ch.visible, out_ch.clip_left, out_ch.clip_top, out_ch.clip_right,
					out_ch.clip_bottom, out_ch.out_u_start, out_ch.out_v_start, out_ch.out_u_end,
					out_ch.out_v_end};
				if (expected_clips.size() == 0) begin
					$display("%0t: result with nothing expected: %p", $time, got);
					error_count++;
				end else begin
					clip_t exp_c;
					exp_c = expected_clips.pop_front();
					if (got !== exp_c) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_c, got);
						error_count++;
					end
				end
			end
			if (hold_off > 0) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= !((phase == PH_SNK_STALL && $urandom_range(99) < 74) ||
					(phase == PH_BOTH && $urandom_range(99) < 17));
			end
		end
	end

	// The long hold-off is counted down here, one step per cycle.
	always @(posedge clk) begin
		if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	// The cycle counter stops a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// A configuration write is issued while the block is idle, and the local copy is updated.
	task automatic write_reg(reg_idx_t idx, logic [CW-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_WIN_LEFT: begin
				win_l = value;
			end
			REG_WIN_TOP: begin
				win_t = value;
			end
			REG_WIN_RIGHT: begin
				win_r = value;
			end
			REG_WIN_BOTTOM: begin
				win_b = value;
			end
			REG_ORIGIN_X: begin
				org_x = value;
			end
			default: begin
				org_y = value;
			end
		endcase
	endtask

	task automatic set_window(logic [CW-1:0] l, logic [CW-1:0] t, logic [CW-1:0] r,
			logic [CW-1:0] b, logic [CW-1:0] ox, logic [CW-1:0] oy);
		write_reg(REG_WIN_LEFT, l);
		write_reg(REG_WIN_TOP, t);
		write_reg(REG_WIN_RIGHT, r);
		write_reg(REG_WIN_BOTTOM, b);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
	endtask

	// Wait until every sprite has been transferred and every result checked,
	// then let the pipeline drain.
	task automatic drain();
		while (pending_sprites.size() > 0 || expected_clips.size() > 0 || in_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TW-1:0] rand_tex();
		case ($urandom_range(5))
			0: return 17'd0;
			1: return 17'd65536;
			2: return '1;
			default: return TW'($urandom_range(65536));
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_coord(int span);
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return CW'($urandom);
			default: return CW'($urandom_range(2 * span) - span);
		endcase
	endfunction

	// Most random sprites are sized to overlap the window so that clipping and
	// texture adjust are exercised, the rest are arbitrary.
	task automatic queue_random(int count);
		sprite_t s;
		for (int i = 0; i < count; i++) begin
			s.x = rand_coord(1200);
			s.y = rand_coord(1200);
			s.w = rand_coord(1500);
			s.h = rand_coord(1500);
			s.us = rand_tex();
			s.vs = rand_tex();
			s.ue = rand_tex();
			s.ve = rand_tex();
			pending_sprites.push_back(s);
		end
	endtask

	task automatic queue_sprite(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] w,
			logic [CW-1:0] h, logic [TW-1:0] us, logic [TW-1:0] vs, logic [TW-1:0] ue,
			logic [TW-1:0] ve);
		pending_sprites.push_back({x, y, w, h, us, vs, ue, ve});
	endtask

	initial begin
		arst_n = 1'b0;
		phase = PH_NONE;
		hold_off = 0;
		error_count = 0;
		cycle_count = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_WIN_LEFT;
		cfg.data = '0;
		in_ch.valid = 1'b0;
		{in_ch.rect_x, in_ch.rect_y, in_ch.rect_w, in_ch.rect_h} = '0;
		{in_ch.tex_u_start, in_ch.tex_v_start, in_ch.tex_u_end, in_ch.tex_v_end} = '0;
		out_ch.ready = 1'b0;
		// These are the register values after reset.
		win_l = '0;
		win_t = '0;
		win_r = 16'sh7fff;
		win_b = 16'sh7fff;
		org_x = '0;
		org_y = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// The directed part runs with the reset registers: extremes of each field,
		// flipped sizes, zero area and texture beyond 1.0.
		queue_sprite(16'sh0010, 16'sh0010, 16'sh0100, 16'sh0100, 17'd0, 17'd0, 17'd65536,
			17'd65536);
		queue_sprite(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 17'd0, 17'd0, '1, '1);
		queue_sprite(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, '1, '1, 17'd0, 17'd0);
		queue_sprite(16'sh0100, 16'sh0100, 16'shff00, 16'shff80, 17'd100, 17'd200, 17'd60000,
			17'd50000);
		queue_sprite(16'sh0100, 16'sh0100, 16'sh8000, 16'sh8000, 17'd65536, 17'd0, 17'd0,
			17'd65536);
		queue_sprite(16'sh0010, 16'sh0010, 16'sh0000, 16'sh0100, 17'd0, 17'd0, 17'd1000,
			17'd1000);
		queue_sprite(16'sh0010, 16'sh0010, 16'sh0100, 16'sh0000, 17'd0, 17'd0, 17'd1000,
			17'd1000);
		queue_sprite(16'shffc0, 16'shffc0, 16'sh0080, 16'sh0080, 17'd0, 17'd0, 17'd65536,
			17'd65536);
		queue_sprite(16'sh7f00, 16'sh7f00, 16'sh0200, 16'sh0200, '1, 17'd0, 17'd0, '1);
		queue_sprite(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 17'h15555, 17'h0aaaa,
			17'h0aaaa, 17'h15555);
		drain();

		// Then an inverted window with a nonzero origin, where nothing is visible.
		set_window(16'sh0100, 16'sh0100, 16'sh0080, 16'sh0080, 16'sh0010, 16'shfff0);
		queue_sprite(16'sh0000, 16'sh0000, 16'sh0200, 16'sh0200, 17'd0, 17'd0, 17'd65536,
			17'd65536);
		queue_sprite(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 17'd0, 17'd0, 17'd65536,
			17'd65536);
		drain();

		// The random part cycles through window settings and idling phases.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: set_window(16'shfc00, 16'shfc00, 16'sh0400, 16'sh0400, 16'sh0000, 16'sh0000);
				1: set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
				2: set_window(CW'($urandom_range(300)), CW'($urandom_range(300)), 16'sh0300,
					16'sh0200, CW'($urandom), CW'($urandom_range(400)));
				default: set_window(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0010,
					16'sh8000, 16'sh7fff);
			endcase
			phase = phase_t'(p % 4);
			// The long hold-off fills the block while the sender keeps offering.
			if (p == 1)
				hold_off = 300;
			queue_random(150);
			drain();
		end

		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

FILE: filelist.f
src/srct_pkg.sv
src/srct_if.sv
src/srct_front.sv
src/srct_fifo.sv
src/srct_div.sv
src/srct_back.sv
src/sprite_rect_clip_texcoord_top.sv
src/srct_checker.sv
dv/sprite_rect_clip_texcoord_top_test.sv
